// File: hw/rtl/skf_pkg.sv
// skf_pkg: shared types, constants and saturation helpers for the scalar
// Kalman update block. No dependencies.
package skf_pkg;

    localparam int FRAC = 16;

    localparam logic signed [31:0] SMAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN   = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_FX = 32'sh0001_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_Q  = 3'd0;
    localparam logic [2:0] CFG_R  = 3'd1;
    localparam logic [2:0] CFG_H  = 3'd2;
    localparam logic [2:0] CFG_X0 = 3'd3;
    localparam logic [2:0] CFG_P0 = 3'd4;

    typedef struct packed {
        logic signed [31:0] measurement;
        logic               available;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] new_estimate;
        logic [30:0]        new_covariance;
        logic signed [31:0] innovation;
        logic [30:0]        innov_var;
        logic signed [31:0] innov_norm;
        logic signed [31:0] kalman_gain;
        logic               updated;
        logic               config_error;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PH, ST_HX, ST_T, ST_K, ST_SQ, ST_NRM, ST_KY, ST_KH, ST_PN, ST_DONE
    } t_state;

    // magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [31:0] mag(input logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    // apply sign to a magnitude, saturating to the signed range
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [48:0] q);
        logic [48:0] lim;
        logic [31:0] v;
        lim = neg ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
        v   = (q > lim) ? lim[31:0] : q[31:0];
        return neg ? -v : v;
    endfunction

    // clamp a 33-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) return SMAX;
        if (v < -33'sh0_8000_0000) return SMIN;
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/skf_mul.sv
// skf_mul: bit-serial shift-add fixed-point multiplier, one multiplier bit
// per cycle, rounded and saturated. Depends on skf_pkg.
module skf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [31:0] o_result
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_mcand, r_mplier;
    logic        r_neg;
    logic [32:0] sum;
    logic [63:0] rounded;

    // one partial product per cycle into the upper half
    assign sum   = {1'b0, r_acc[63:32]} + (r_mplier[0] ? {1'b0, r_mcand} : 33'd0);
    assign n_acc = {sum, r_acc[31:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= skf_pkg::mag(i_a);
            r_mplier <= skf_pkg::mag(i_b);
            r_neg    <= i_a[31] ^ i_b[31];
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mplier <= {1'b0, r_mplier[31:1]};
        end
    end

    // round to nearest, ties away from zero, then saturate
    assign rounded  = (r_acc + 64'd32768) >> skf_pkg::FRAC;
    assign o_result = skf_pkg::sat_mag(r_neg, {1'b0, rounded[47:0]});
    assign o_done   = r_done;

endmodule

// File: hw/rtl/skf_div.sv
// skf_div: restoring radix-2 fixed-point divider, one quotient bit per
// cycle, rounded and saturated. Depends on skf_pkg.
module skf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [31:0] o_result
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_num, r_quot;
    logic [31:0] r_rem, r_d;
    logic        r_neg;
    logic [32:0] r2, diff;
    logic        ge, rnd;
    logic [48:0] q;

    assign r2   = {r_rem, r_num[47]};
    assign diff = r2 - {1'b0, r_d};
    assign ge   = r2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {skf_pkg::mag(i_a), 16'd0};
            r_rem  <= '0;
            r_quot <= '0;
            r_d    <= skf_pkg::mag(i_b);
            r_neg  <= i_a[31] ^ i_b[31];
        end else if (r_busy) begin
            r_num  <= {r_num[46:0], 1'b0};
            r_rem  <= ge ? diff[31:0] : r2[31:0];
            r_quot <= {r_quot[46:0], ge};
        end
    end

    // round up when the remainder is at least half the divisor
    assign rnd      = {r_rem, 1'b0} >= {1'b0, r_d};
    assign q        = {1'b0, r_quot} + {48'd0, rnd};
    assign o_result = (r_d == 32'd0) ? 32'sd0 : skf_pkg::sat_mag(r_neg, q);
    assign o_done   = r_done;

endmodule

// File: hw/rtl/skf_sqrt.sv
// skf_sqrt: digit-by-digit integer square root of s scaled by 2^16, one
// root bit per cycle. Depends on skf_pkg.
module skf_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [30:0]        i_s,
    output logic               o_done,
    output logic signed [31:0] o_root
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [47:0] r_rad;
    logic [25:0] r_rem;
    logic [23:0] r_root;
    logic [27:0] r2, trial, diff;
    logic        ge;

    assign r2    = {r_rem, r_rad[47:46]};
    assign trial = {2'b00, r_root, 2'b01};
    assign diff  = r2 - trial;
    assign ge    = r2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_s, 16'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[45:0], 2'b00};
            r_rem  <= ge ? diff[25:0] : r2[25:0];
            r_root <= {r_root[22:0], ge};
        end
    end

    assign o_root = {8'd0, r_root};
    assign o_done = r_done;

endmodule

// File: hw/rtl/scalar_kalman_update.sv
// scalar_kalman_update: top level, step sequencer and state registers.
// Depends on skf_pkg, skf_mul, skf_div and skf_sqrt.
//
// One-state Kalman filter in signed Q16.16. A request with a measurement
// runs six multiplies on a bit-serial multiplier, two divides on a radix-2
// divider and one square root back to back before its result is ready; a
// predict-only request or one under invalid settings (R = 0 or H = 0) goes
// straight to the result stage. The block returns to idle, and can accept
// the next request, as the result register loads. One request is worked on
// at a time; the next can be accepted while the previous result waits in
// the output register, and a finished request waits while that register
// still holds an unaccepted result. Configuration writes are accepted every
// cycle and must be made while the block is idle.
module scalar_kalman_update (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  skf_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output skf_pkg::t_out_req o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    skf_pkg::t_state r_state, n_state;
    logic            r_started, n_started;

    // configuration and filter state
    logic [30:0]        r_q, r_r, r_cov;
    logic signed [31:0] r_h, r_est;

    // working values of the current request
    logic signed [31:0] r_z, r_x, r_ph, r_y, r_k, r_sq, r_nrm, r_om;
    logic signed [31:0] n_x, n_ph, n_y, n_k, n_sq, n_nrm, n_om;
    logic [30:0]        r_p, r_s, n_p, n_s;
    logic               r_upd, r_err, n_upd, n_err;

    logic              r_out_valid, n_out_valid;
    skf_pkg::t_out_req r_out, n_out;
    logic              out_load, accept;

    // serial units
    logic               mul_start, div_start, sq_start;
    logic               mul_done, div_done, sq_done;
    logic signed [31:0] mul_a, mul_b, div_a, div_b, mul_res, div_res, sq_res;
    logic signed [31:0] tmp;

    logic [31:0] p_sum;
    logic [30:0] p_pred;
    logic        bad_cfg;

    skf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_result(mul_res)
    );

    skf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(div_a), .i_b(div_b), .o_done(div_done), .o_result(div_res)
    );

    skf_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_s(r_s), .o_done(sq_done), .o_root(sq_res)
    );

    // prediction: covariance plus Q, saturated
    assign p_sum   = {1'b0, r_cov} + {1'b0, r_q};
    assign p_pred  = p_sum[31] ? 31'h7FFF_FFFF : p_sum[30:0];
    assign bad_cfg = (r_r == 31'd0) || (r_h == 32'sd0);

    assign o_in_ready  = (r_state == skf_pkg::ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_x = r_x;  n_ph = r_ph; n_y = r_y;   n_k = r_k;  n_sq = r_sq;
        n_nrm = r_nrm; n_om = r_om; n_p = r_p; n_s = r_s;
        n_upd = r_upd; n_err = r_err;
        mul_start = 1'b0; div_start = 1'b0; sq_start = 1'b0;
        mul_a = r_h; mul_b = r_x; div_a = r_ph; div_b = {1'b0, r_s};
        out_load = 1'b0;
        tmp = '0;
        case (r_state)
            skf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_x = r_est; n_y = '0; n_s = '0; n_k = '0; n_nrm = '0;
                    n_upd = 1'b0; n_err = bad_cfg;
                    n_p = bad_cfg ? r_cov : p_pred;
                    n_started = 1'b0;
                    n_state = (!bad_cfg && i_in_data.available) ? skf_pkg::ST_PH
                                                                : skf_pkg::ST_DONE;
                end
            end
            skf_pkg::ST_PH: begin
                mul_a = {1'b0, r_p}; mul_b = r_h;
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    n_ph = mul_res; n_started = 1'b0; n_state = skf_pkg::ST_HX;
                end
            end
            skf_pkg::ST_HX: begin
                mul_a = r_h; mul_b = r_x;
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    n_y = skf_pkg::sat33({r_z[31], r_z} - {mul_res[31], mul_res});
                    n_started = 1'b0; n_state = skf_pkg::ST_T;
                end
            end
            skf_pkg::ST_T: begin
                mul_a = r_ph; mul_b = r_h;
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    tmp = skf_pkg::sat33({mul_res[31], mul_res} + {2'b00, r_r});
                    n_s = tmp[31] ? 31'd0 : tmp[30:0];
                    n_started = 1'b0; n_state = skf_pkg::ST_K;
                end
            end
            skf_pkg::ST_K: begin
                div_a = r_ph; div_b = {1'b0, r_s};
                div_start = !r_started; n_started = 1'b1;
                if (div_done) begin
                    n_k = div_res; n_started = 1'b0; n_state = skf_pkg::ST_SQ;
                end
            end
            skf_pkg::ST_SQ: begin
                sq_start = !r_started; n_started = 1'b1;
                if (sq_done) begin
                    n_sq = sq_res; n_started = 1'b0; n_state = skf_pkg::ST_NRM;
                end
            end
            skf_pkg::ST_NRM: begin
                div_a = r_y; div_b = r_sq;
                div_start = !r_started; n_started = 1'b1;
                if (div_done) begin
                    n_nrm = div_res; n_started = 1'b0; n_state = skf_pkg::ST_KY;
                end
            end
            skf_pkg::ST_KY: begin
                mul_a = r_k; mul_b = r_y;
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    n_x = skf_pkg::sat33({r_x[31], r_x} + {mul_res[31], mul_res});
                    n_started = 1'b0; n_state = skf_pkg::ST_KH;
                end
            end
            skf_pkg::ST_KH: begin
                mul_a = r_k; mul_b = r_h;
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    n_om = skf_pkg::sat33({1'b0, skf_pkg::ONE_FX}
                                          - {mul_res[31], mul_res});
                    n_started = 1'b0; n_state = skf_pkg::ST_PN;
                end
            end
            skf_pkg::ST_PN: begin
                mul_a = r_om; mul_b = {1'b0, r_p};
                mul_start = !r_started; n_started = 1'b1;
                if (mul_done) begin
                    n_p = mul_res[31] ? 31'd0 : mul_res[30:0];
                    n_upd = 1'b1; n_started = 1'b0; n_state = skf_pkg::ST_DONE;
                end
            end
            skf_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state = skf_pkg::ST_IDLE;
                end
            end
            default: n_state = skf_pkg::ST_IDLE;
        endcase
    end

    // result assembly
    always_comb begin
        n_out.new_estimate   = r_x;
        n_out.new_covariance = r_p;
        n_out.innovation     = r_y;
        n_out.innov_var      = r_s;
        n_out.innov_norm     = r_nrm;
        n_out.kalman_gain    = r_k;
        n_out.updated        = r_upd;
        n_out.config_error   = r_err;
        n_out_valid = out_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skf_pkg::ST_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_q   <= '0;
            r_r   <= 31'h0001_0000;
            r_h   <= skf_pkg::ONE_FX;
            r_est <= '0;
            r_cov <= 31'h0001_0000;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            // commit the filter state with the result
            if (out_load) begin
                r_est <= r_x;
                r_cov <= r_p;
            end
            // configuration writes; x0 and P0 load the filter state directly
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    skf_pkg::CFG_Q:  r_q <= i_cfg_data[30:0];
                    skf_pkg::CFG_R:  r_r <= i_cfg_data[30:0];
                    skf_pkg::CFG_H:  r_h <= i_cfg_data;
                    skf_pkg::CFG_X0: r_est <= i_cfg_data;
                    skf_pkg::CFG_P0: r_cov <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) r_z <= i_in_data.measurement;
        r_x <= n_x;   r_ph <= n_ph; r_y <= n_y;   r_k <= n_k;  r_sq <= n_sq;
        r_nrm <= n_nrm; r_om <= n_om; r_p <= n_p; r_s <= n_s;
        r_upd <= n_upd; r_err <= n_err;
        if (out_load) r_out <= n_out;
    end

endmodule

// File: sim/scalar_kalman_update_tb.sv
// scalar_kalman_update_tb: self-checking bench for the scalar Kalman update block.
// Depends on skf_pkg and scalar_kalman_update; drives random and table-driven
// requests, predicts each result in Q16.16 and compares it field by field.
`timescale 1ns / 100ps

module scalar_kalman_update_tb;

    localparam logic [2:0] CFG_UNUSED = 3'd7;   // index with no register behind it
    localparam int         IDLE_PCT   = 9;
    localparam int         STALL_MAX  = 20000;  // cycles with no handshake at all
    localparam int         SETTLE     = 16;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         idx;
        logic [31:0]        val;
        bit                 avail;
        bit                 typed;
        skf_pkg::t_out_req  want;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    skf_pkg::t_in_req  in_data = '0;
    logic     out_ready = 1'b1;
    logic     cfg_valid = 1'b0;
    logic [2:0]  cfg_index = skf_pkg::CFG_Q;
    logic [31:0] cfg_data = '0;
    logic     o_in_ready, o_out_valid, o_cfg_ready;
    skf_pkg::t_out_req o_out_data;

    // filter state and settings as the bench sees them
    logic [30:0]        flt_q, flt_r, flt_cov;
    logic signed [31:0] flt_h, flt_est;

    skf_pkg::t_out_req pending_results[$];
    t_row     plan[$];
    int       errors = 0;
    int       quiet = 0;
    bit       calm = 1'b0;

    scalar_kalman_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---- fixed-point arithmetic of the filter ----
    function automatic longint clip(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] absval(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint signed_sat(bit neg, logic [63:0] q);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // rounded Q16.16 product, ties away from zero
    function automatic longint qmul(longint a, longint b);
        logic [63:0] p;
        p = absval(a) * absval(b) + 64'h8000;
        return signed_sat((a < 0) != (b < 0), p >> skf_pkg::FRAC);
    endfunction

    // rounded Q16.16 quotient
    function automatic longint qdiv(longint a, longint b);
        logic [63:0] n, d, q, r;
        d = absval(b);
        if (d == 0) return 0;
        n = absval(a) << skf_pkg::FRAC;
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        return signed_sat((a < 0) != (b < 0), q);
    endfunction

    // truncated root of s, result in Q16.16
    function automatic longint qsqrt(longint s);
        logic [63:0] v, root, c;
        v = 64'(s) << skf_pkg::FRAC;
        root = 0;
        for (int i = 23; i >= 0; i--) begin
            c = root | (64'd1 << i);
            if (c * c <= v) root = c;
        end
        return longint'(root);
    endfunction

    function automatic longint nonneg(longint v);
        return (v < 0) ? 0 : v;
    endfunction

    // one filter step; updates the bench copy of estimate and covariance
    function automatic skf_pkg::t_out_req filter_step(logic signed [31:0] z, bit avail);
        skf_pkg::t_out_req res;
        longint   x, p, ph, y, s, k, nrm;
        bit       bad;
        x = flt_est; p = flt_cov; y = 0; s = 0; k = 0; nrm = 0;
        bad = (flt_r == 0) || (flt_h == 0);
        res = '0;
        if (!bad) begin
            p = nonneg(clip(p + longint'(flt_q)));
            if (avail) begin
                ph  = qmul(p, flt_h);
                y   = clip(longint'(z) - qmul(flt_h, x));
                s   = nonneg(clip(qmul(ph, flt_h) + longint'(flt_r)));
                k   = qdiv(ph, s);
                nrm = qdiv(y, qsqrt(s));
                x   = clip(x + qmul(k, y));
                p   = nonneg(qmul(clip(longint'(skf_pkg::ONE_FX) - qmul(k, flt_h)), p));
                res.updated = 1'b1;
            end
            flt_est = x[31:0];
            flt_cov = p[30:0];
        end
        res.new_estimate   = flt_est;
        res.new_covariance = flt_cov;
        res.innovation     = y[31:0];
        res.innov_var      = s[30:0];
        res.innov_norm     = nrm[31:0];
        res.kalman_gain    = k[31:0];
        res.config_error   = bad;
        return res;
    endfunction

    function automatic void apply_setting(logic [2:0] idx, logic [31:0] val);
        case (idx)
            skf_pkg::CFG_Q:  flt_q = val[30:0];
            skf_pkg::CFG_R:  flt_r = val[30:0];
            skf_pkg::CFG_H:  flt_h = val;
            skf_pkg::CFG_X0: flt_est = val;
            skf_pkg::CFG_P0: flt_cov = val[30:0];
            default: ;
        endcase
    endfunction

    // ---- drivers ----
    task automatic write_setting(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_setting(idx, val);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // send one measurement request; valid stays up for a back-to-back request
    task automatic send_request(logic signed [31:0] z, bit avail, bit typed,
                                skf_pkg::t_out_req want);
        skf_pkg::t_out_req got;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{measurement: z, available: avail};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = filter_step(z, avail);
        pending_results.insert(pending_results.size(), typed ? want : got);
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---- result checking ----
    task automatic report(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        skf_pkg::t_out_req w;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding", $realtime);
                errors++;
            end else begin
                w = pending_results.pop_front();
                if (o_out_data.new_estimate !== w.new_estimate)
                    report("new_estimate", o_out_data.new_estimate, w.new_estimate);
                if (o_out_data.new_covariance !== w.new_covariance)
                    report("new_covariance", o_out_data.new_covariance, w.new_covariance);
                if (o_out_data.innovation !== w.innovation)
                    report("innovation", o_out_data.innovation, w.innovation);
                if (o_out_data.innov_var !== w.innov_var)
                    report("innov_var", o_out_data.innov_var, w.innov_var);
                if (o_out_data.innov_norm !== w.innov_norm)
                    report("innov_norm", o_out_data.innov_norm, w.innov_norm);
                if (o_out_data.kalman_gain !== w.kalman_gain)
                    report("kalman_gain", o_out_data.kalman_gain, w.kalman_gain);
                if (o_out_data.updated !== w.updated)
                    report("updated", o_out_data.updated, w.updated);
                if (o_out_data.config_error !== w.config_error)
                    report("config_error", o_out_data.config_error, w.config_error);
            end
        end
    end

    // watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= STALL_MAX) begin
            $display("scalar_kalman_update_tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---- directed table ----
    function automatic void plan_setting(logic [2:0] idx, logic [31:0] val);
        plan.insert(plan.size(), '{is_cfg: 1'b1, idx: idx, val: val, avail: 1'b0,
                                   typed: 1'b0, want: '0});
    endfunction

    function automatic void plan_request(logic [31:0] z, bit avail);
        plan.insert(plan.size(), '{is_cfg: 1'b0, idx: skf_pkg::CFG_Q, val: z,
                                   avail: avail, typed: 1'b0, want: '0});
    endfunction

    function automatic void plan_typed(logic [31:0] z, bit avail, skf_pkg::t_out_req want);
        plan.insert(plan.size(), '{is_cfg: 1'b0, idx: skf_pkg::CFG_Q, val: z,
                                   avail: avail, typed: 1'b1, want: want});
    endfunction

    function automatic logic [31:0] pick_word(bit full_range);
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return full_range ? $urandom : 32'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    initial begin
        t_row     row;
        skf_pkg::t_out_req w;
        logic [31:0] v;

        // state and settings right after reset
        flt_q = '0; flt_r = 31'(skf_pkg::ONE_FX); flt_h = skf_pkg::ONE_FX;
        flt_est = '0; flt_cov = 31'(skf_pkg::ONE_FX);

        // predict only from reset: covariance stays at one
        w = '0; w.new_covariance = 31'h1_0000;
        plan_typed(32'h0, 1'b0, w);
        // unit filter, z = 1.0: gain 0.5, S = 2.0
        w = '{new_estimate: 32'h8000, new_covariance: 31'h8000, innovation: 32'h1_0000,
              innov_var: 31'h2_0000, innov_norm: 32'd46341,
              kalman_gain: 32'h8000, updated: 1'b1, config_error: 1'b0};
        plan_typed(32'h1_0000, 1'b1, w);
        // zero measurement variance is rejected, state held
        plan_setting(skf_pkg::CFG_R, 32'h0);
        w = '0; w.new_estimate = 32'h8000; w.new_covariance = 31'h8000; w.config_error = 1'b1;
        plan_typed(32'h5_0000, 1'b1, w);
        // zero observation gain likewise
        plan_setting(skf_pkg::CFG_R, 32'h1_0000);
        plan_setting(skf_pkg::CFG_H, 32'h0);
        plan_typed(32'h7FFF_FFFF, 1'b1, w);
        // extremes everywhere
        plan_setting(skf_pkg::CFG_H, 32'h8000_0000);
        plan_setting(skf_pkg::CFG_X0, 32'h7FFF_FFFF);
        plan_setting(skf_pkg::CFG_P0, 32'h7FFF_FFFF);
        plan_setting(skf_pkg::CFG_Q, 32'h7FFF_FFFF);
        plan_request(32'h8000_0000, 1'b1);
        plan_request(32'h7FFF_FFFF, 1'b1);
        plan_request(32'h0, 1'b0);
        plan_setting(CFG_UNUSED, 32'hFFFF_FFFF);
        plan_request(32'hFFFF_FFFF, 1'b1);
        plan_setting(skf_pkg::CFG_H, 32'h7FFF_FFFF);
        plan_setting(skf_pkg::CFG_X0, 32'h8000_0000);
        plan_setting(skf_pkg::CFG_Q, 32'h0);
        plan_setting(skf_pkg::CFG_R, 32'h1);
        plan_request(32'h7FFF_FFFF, 1'b1);
        plan_request(32'h8000_0000, 1'b1);
        plan_setting(skf_pkg::CFG_R, 32'h7FFF_FFFF);
        plan_setting(skf_pkg::CFG_P0, 32'h0);
        plan_request(32'h0, 1'b1);
        plan_request(32'h1, 1'b1);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                drain();
                write_setting(row.idx, row.val);
            end else begin
                send_request(row.val, row.avail, row.typed, row.want);
            end
        end

        // random phases, each under its own settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            calm = (ph == 3);
            for (int r = 0; r < 5; r++) begin
                if (ph == 0 || $urandom_range(1)) begin
                    case (r)
                        0: v = ($urandom_range(3) == 0) ? pick_word(1) : $urandom_range(0, 262144);
                        1: v = ($urandom_range(15) == 0) ? 32'h0 :
                               ($urandom_range(3) == 0) ? pick_word(1) :
                               $urandom_range(1, 1048576);
                        2: v = ($urandom_range(15) == 0) ? 32'h0 : pick_word(ph[0]);
                        3: v = pick_word(ph[1]);
                        default: v = ($urandom_range(3) == 0) ? pick_word(1) :
                                     $urandom_range(0, 1048576);
                    endcase
                    write_setting(3'(r), v);
                end
            end
            if ($urandom_range(3) == 0) write_setting(3'($urandom_range(5, 7)), $urandom);
            for (int n = 0; n < 119; n++) begin
                v = ($urandom_range(3) == 0) ? $urandom : pick_word(1);
                send_request(v, $urandom_range(99) < 80, 1'b0, '0);
            end
        end
        calm = 1'b0;
        drain();

        if (errors == 0) begin
            $display("scalar_kalman_update_tb: done, clean");
        end else begin
            $display("scalar_kalman_update_tb: done, errors");
        end
        $finish;
    end

endmodule
